/* rtl/hkf_pkg.sv */
`default_nettype none
package hkf_pkg;
    localparam int W = 32;
    localparam logic [1:0] ST_PRED = 2'd0;
    localparam logic [1:0] ST_CORR = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;
    localparam logic [2:0] REG_ACCEL = 3'd0;
    localparam logic [2:0] REG_SONAR = 3'd1;
    localparam logic [2:0] REG_GRAV = 3'd2;
    localparam logic [2:0] REG_MIN = 3'd3;
    localparam logic [2:0] REG_START = 3'd4;
    localparam logic signed [31:0] SMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] SMIN = 32'sh80000000;

    typedef struct packed {
        logic start;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_mul_req;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        r = v[31:0];
        if (v > 64'sh000000007FFFFFFF) r = SMAX;
        if (v < -64'sh0000000080000000) r = SMIN;
        return r;
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [32:0] s;
        logic signed [31:0] r;
        s = {a[31], a} + {b[31], b};
        r = s[31:0];
        if (s[32] != s[31]) r = s[32] ? SMIN : SMAX;
        return r;
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [32:0] s;
        logic signed [31:0] r;
        s = {a[31], a} - {b[31], b};
        r = s[31:0];
        if (s[32] != s[31]) r = s[32] ? SMIN : SMAX;
        return r;
    endfunction
endpackage
`default_nettype wire

/* rtl/hkf_mul.sv */
`default_nettype none
module hkf_mul #(
    parameter int FRAC_BITS = 16
) (
    input  wire  logic                i_clk,
    input  wire  logic                i_rst_n,
    input  wire  hkf_pkg::t_mul_req   i_req,
    output logic                      o_done,
    output logic signed [31:0]        o_p
);
    logic [31:0] r_a, n_a;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_b, n_b;
    logic        r_neg, n_neg;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic signed [63:0] prod;

    assign prod = r_neg ? -$signed(r_acc) : $signed(r_acc);

    always_comb begin
        n_a = r_a; n_b = r_b; n_acc = r_acc; n_neg = r_neg;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        if (i_req.start) begin
            n_a = i_req.a[31] ? 32'(-i_req.a) : i_req.a;
            n_b = {32'd0, (i_req.b[31] ? 32'(-i_req.b) : i_req.b)};
            n_neg = i_req.a[31] ^ i_req.b[31];
            n_acc = '0; n_cnt = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_a[0]) n_acc = r_acc + r_b;
            n_a = r_a >> 1;
            n_b = r_b << 1;
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_a <= n_a; r_b <= n_b; r_acc <= n_acc; r_neg <= n_neg; r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_p = hkf_pkg::sat64(prod >>> FRAC_BITS);
endmodule
`default_nettype wire

/* rtl/hkf_div.sv */
`default_nettype none
module hkf_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire  logic         i_clk,
    input  wire  logic         i_rst_n,
    input  wire  logic         i_start,
    input  wire  logic signed [31:0] i_n,
    input  wire  logic signed [31:0] i_d,
    output logic               o_done,
    output logic signed [31:0] o_q
);
    localparam int NB = 32 + FRAC_BITS;
    logic [NB-1:0] r_q, n_q;
    logic [32:0]   r_rem, n_rem;
    logic [31:0]   r_d, n_d;
    logic          r_neg, n_neg;
    logic [5:0]    r_cnt, n_cnt;
    logic          r_busy, n_busy, r_done, n_done;
    logic [32:0]   sh;
    logic signed [NB:0] sq;
    logic signed [63:0] wq;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_d = r_d; n_neg = r_neg;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        sh = {r_rem[31:0], r_q[NB-1]};
        if (i_start) begin
            n_q = NB'({(i_n[31] ? 32'(-i_n) : i_n)}) << FRAC_BITS;
            n_d = i_d[31] ? 32'(-i_d) : i_d;
            n_neg = i_n[31] ^ i_d[31];
            n_rem = '0; n_cnt = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            n_q = r_q << 1;
            if (sh >= {1'b0, r_d}) begin
                n_rem = sh - {1'b0, r_d};
                n_q[0] = 1'b1;
            end else begin
                n_rem = sh;
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'(NB - 1)) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_q <= n_q; r_rem <= n_rem; r_d <= n_d; r_neg <= n_neg; r_cnt <= n_cnt;
    end

    assign sq = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    assign wq = 64'(sq);
    assign o_done = r_done;
    assign o_q = (r_d == 32'd0) ? 32'sd0 : hkf_pkg::sat64(wq);
endmodule
`default_nettype wire

/* rtl/height_kalman_filter.sv */
// Vertical height/speed Kalman filter, signed Q fixed point.
// Input channel: i_valid/o_stall carries one item (cmd, stamp, accel_z,
// range_value, range_limit). cmd 0 predicts from acceleration, cmd 1
// corrects with a sonar range.
// Output channel: o_valid/i_stall carries one result per item: the state
// and covariance after the item plus a status code.
// One item is worked at a time. A predict takes 12 products on a shift-add
// multiplier. A correct takes two divisions on a restoring divider and five
// products. A skipped item shows its result the cycle after it is taken.
// After a result is taken the filter returns to idle before it takes the
// next item.
// o_stall is high while an item is worked or its result waits; a
// stalled result holds until taken.
// Reset (i_rst_n low, synchronous) loads the register defaults, height 0,
// speed 0, covariances 1000.0 and last stamp 0.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) apply at once.
// A write to start_height is accepted and has no effect, since the filter
// keeps no register for that index.
`default_nettype none
module height_kalman_filter #(
    parameter int FRAC_BITS = 16
) (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_cfg_we,
    input  wire  logic [2:0]  i_cfg_index,
    input  wire  logic [31:0] i_cfg_data,
    input  wire  logic        i_valid,
    output logic              o_stall,
    input  wire  logic        i_cmd,
    input  wire  logic [31:0] i_stamp,
    input  wire  logic signed [31:0] i_accel_z,
    input  wire  logic [30:0] i_range_value,
    input  wire  logic [30:0] i_range_limit,
    output logic              o_valid,
    input  wire  logic        i_stall,
    output logic signed [31:0] o_height,
    output logic signed [31:0] o_vertical_speed,
    output logic signed [31:0] o_height_var,
    output logic signed [31:0] o_cross_cov,
    output logic signed [31:0] o_speed_var,
    output logic [1:0]        o_status
);
    localparam logic signed [63:0] INIT64 = 64'sd1000 <<< FRAC_BITS;
    localparam logic signed [31:0] INIT_COV = hkf_pkg::sat64(INIT64);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_MSTART = 6'b000010, S_MWAIT = 6'b000100,
        S_DSTART = 6'b001000, S_DWAIT = 6'b010000, S_OUT = 6'b100000
    } t_state;

    t_state r_st, n_st;
    logic [30:0] r_qa, r_rs, r_g;
    logic [31:0] r_min, r_last;
    logic signed [31:0] r_h, r_v, r_hh, r_hs, r_ss;
    logic signed [31:0] r_dt, r_u, r_w0, r_t0, r_t1, r_t2, r_innov, r_s, r_k0, r_k1;
    logic r_cmd;
    logic [3:0] r_step;
    logic [1:0] r_status;
    logic signed [31:0] ma, mb;
    hkf_pkg::t_mul_req mreq;
    logic mdone, ddone;
    logic signed [31:0] mp, dq;
    logic [31:0] dtraw;
    logic [3:0] last_step;

    assign dtraw = i_stamp - r_last;

    hkf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk, .i_rst_n, .i_req(mreq), .o_done(mdone), .o_p(mp));
    hkf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk, .i_rst_n, .i_start(r_st == S_DSTART),
        .i_n(r_step == 4'd0 ? r_hh : r_hs), .i_d(r_s), .o_done(ddone), .o_q(dq));

    always_comb begin
        ma = r_dt; mb = r_v;
        if (!r_cmd) begin
            unique case (r_step)
                4'd0: begin ma = r_dt; mb = r_dt; end
                4'd1: begin ma = r_dt; mb = r_v; end
                4'd2: begin ma = r_w0; mb = r_u; end
                4'd3: begin ma = r_dt; mb = r_u; end
                4'd4: begin ma = r_dt; mb = r_ss; end
                4'd5: begin ma = r_dt; mb = r_hs; end
                4'd6: begin ma = r_dt; mb = r_t0; end
                4'd7: begin ma = r_w0; mb = $signed({1'b0, r_qa}); end
                4'd8: begin ma = r_w0; mb = r_t2; end
                4'd9: begin ma = r_dt; mb = r_t2; end
                4'd10: begin ma = r_dt; mb = $signed({1'b0, r_qa}); end
                4'd11: begin ma = r_t2; mb = r_dt; end
                default: begin ma = r_dt; mb = r_dt; end
            endcase
        end else begin
            unique case (r_step)
                4'd0: begin ma = r_k0; mb = r_innov; end
                4'd1: begin ma = r_k1; mb = r_innov; end
                4'd2: begin ma = r_k0; mb = r_hh; end
                4'd3: begin ma = r_k0; mb = r_hs; end
                4'd4: begin ma = r_k1; mb = r_t1; end
                default: begin ma = r_k0; mb = r_innov; end
            endcase
        end
        mreq.start = (r_st == S_MSTART);
        mreq.a = ma;
        mreq.b = mb;
        last_step = r_cmd ? 4'd4 : 4'd11;
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_valid) begin
                if (!i_cmd) n_st = (dtraw < r_min) ? S_OUT : S_MSTART;
                else n_st = (i_range_value > i_range_limit) ? S_OUT : S_DSTART;
            end
            S_MSTART: n_st = S_MWAIT;
            S_MWAIT:  if (mdone) n_st = (r_step == last_step) ? S_OUT : S_MSTART;
            S_DSTART: n_st = S_DWAIT;
            S_DWAIT:  if (ddone) n_st = (r_step == 4'd1) ? S_MSTART : S_DSTART;
            S_OUT:    if (!i_stall) n_st = S_IDLE;
            default:  n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_qa <= 31'd13107; r_rs <= 31'd13107; r_g <= 31'd642908;
            r_min <= 32'd66;
            r_h <= '0; r_v <= '0;
            r_hh <= INIT_COV; r_hs <= INIT_COV; r_ss <= INIT_COV;
            r_last <= '0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    hkf_pkg::REG_ACCEL: r_qa <= i_cfg_data[30:0];
                    hkf_pkg::REG_SONAR: r_rs <= i_cfg_data[30:0];
                    hkf_pkg::REG_GRAV:  r_g <= i_cfg_data[30:0];
                    hkf_pkg::REG_MIN:   r_min <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_st)
                S_IDLE: if (i_valid) begin
                    r_cmd <= i_cmd;
                    r_step <= '0;
                    if (!i_cmd) begin
                        r_last <= i_stamp;
                        r_dt <= dtraw[31] ? hkf_pkg::SMAX : $signed(dtraw);
                        r_u <= hkf_pkg::qsub(i_accel_z, $signed({1'b0, r_g}));
                        if (dtraw < r_min) r_status <= hkf_pkg::ST_SHORT;
                        else r_status <= hkf_pkg::ST_PRED;
                    end else begin
                        r_innov <= hkf_pkg::qsub($signed({1'b0, i_range_value}), r_h);
                        r_s <= hkf_pkg::qadd(r_hh, $signed({1'b0, r_rs}));
                        if (i_range_value > i_range_limit) r_status <= hkf_pkg::ST_RANGE;
                        else r_status <= hkf_pkg::ST_CORR;
                    end
                end
                S_DWAIT: if (ddone) begin
                    if (r_step == 4'd0) begin
                        r_k0 <= dq; r_step <= 4'd1;
                    end else begin
                        r_k1 <= dq; r_step <= 4'd0;
                    end
                end
                S_MWAIT: if (mdone) begin
                    r_step <= r_step + 4'd1;
                    if (!r_cmd) begin
                        unique case (r_step)
                            4'd0: r_w0 <= mp >>> 1;
                            4'd1: r_t1 <= hkf_pkg::qadd(r_h, mp);
                            4'd2: r_h <= hkf_pkg::qadd(r_t1, mp);
                            4'd3: r_v <= hkf_pkg::qadd(r_v, mp);
                            4'd4: r_t0 <= hkf_pkg::qadd(r_hs, mp);
                            4'd5: r_t1 <= hkf_pkg::qadd(r_hh, mp);
                            4'd6: r_t1 <= hkf_pkg::qadd(r_t1, mp);
                            4'd7: r_t2 <= mp;
                            4'd8: r_hh <= hkf_pkg::qadd(r_t1, mp);
                            4'd9: r_hs <= hkf_pkg::qadd(r_t0, mp);
                            4'd10: r_t2 <= mp;
                            4'd11: r_ss <= hkf_pkg::qadd(r_ss, mp);
                            default: ;
                        endcase
                    end else begin
                        unique case (r_step)
                            4'd0: r_h <= hkf_pkg::qadd(r_h, mp);
                            4'd1: r_v <= hkf_pkg::qadd(r_v, mp);
                            4'd2: r_t0 <= hkf_pkg::qsub(r_hh, mp);
                            4'd3: begin
                                r_t1 <= r_hs; r_hs <= hkf_pkg::qsub(r_hs, mp);
                                r_hh <= r_t0;
                            end
                            4'd4: r_ss <= hkf_pkg::qsub(r_ss, hkf_pkg::sat64(64'(mp)));
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stall = (r_st != S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_height = r_h;
    assign o_vertical_speed = r_v;
    assign o_height_var = r_hh;
    assign o_cross_cov = r_hs;
    assign o_speed_var = r_ss;
    assign o_status = r_status;
endmodule
`default_nettype wire

/* rtl/hkf_checker.sv */
`default_nettype none
module hkf_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_stall,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire logic [1:0] o_status,
    input wire logic signed [31:0] o_height
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_height) && $stable(o_status))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input taken while result waits");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("no busy after accept");
endmodule
bind height_kalman_filter hkf_checker u_chk (.i_clk, .i_rst_n, .i_valid, .o_stall,
    .o_valid, .i_stall, .o_status, .o_height);
`default_nettype wire

/* bench/tb_top.sv */
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam int QUIET_LIMIT = 20000;
    localparam int SETTLE = 600;
    localparam int HOLD_LEN = 3000;
    localparam logic signed [31:0] COV0 = 32'sd65536000;

    typedef struct {
        logic        cmd;
        logic [31:0] stamp;
        logic signed [31:0] accel;
        logic [30:0] rv;
        logic [30:0] rl;
    } t_item;

    typedef struct {
        logic signed [31:0] h;
        logic signed [31:0] v;
        logic signed [31:0] hh;
        logic signed [31:0] hs;
        logic signed [31:0] ss;
        logic [1:0]  st;
    } t_est;

    typedef struct {
        t_item       it;
        logic        known;
        logic [1:0]  kst;
        logic        cfg_en;
        logic [2:0]  cfg_idx;
        logic [31:0] cfg_dat;
    } t_row;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [2:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_valid = 0;
    logic o_stall;
    logic i_cmd = 0;
    logic [31:0] i_stamp = '0;
    logic signed [31:0] i_accel_z = '0;
    logic [30:0] i_range_value = '0;
    logic [30:0] i_range_limit = '0;
    logic o_valid;
    logic i_stall = 0;
    logic signed [31:0] o_height, o_vertical_speed, o_height_var, o_cross_cov, o_speed_var;
    logic [1:0] o_status;

    height_kalman_filter #(.FRAC_BITS(FB)) dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    logic signed [31:0] m_h = 0, m_v = 0, m_hh = COV0, m_hs = COV0, m_ss = COV0;
    logic [31:0] m_last = 0;
    logic [30:0] k_acc = 31'd13107, k_son = 31'd13107, k_grav = 31'd642908;
    logic [31:0] k_min = 32'd66;

    t_est pending[$];
    t_row rows[$];
    int   fails = 0;
    int   mode = 0;
    bit   hold_req = 0;
    int   quiet = 0;

    function automatic logic signed [31:0] clip(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return hkf_pkg::SMAX;
        if (x < -64'sd2147483648) return hkf_pkg::SMIN;
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] x, y;
        x = 64'(a);
        y = 64'(b);
        return clip(x + y);
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] x, y;
        x = 64'(a);
        y = 64'(b);
        return clip(x - y);
    endfunction

    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] x, y;
        x = 64'(a);
        y = 64'(b);
        return clip((x * y) >>> FB);
    endfunction

    function automatic logic signed [31:0] fx_div(input logic signed [31:0] n,
                                                  input logic signed [31:0] d);
        logic signed [63:0] x, y;
        if (d == 0) return 0;
        x = 64'(n);
        y = 64'(d);
        x = x <<< FB;
        return clip(x / y);
    endfunction

    function automatic t_est filter_step(input t_item it);
        t_est r;
        logic [31:0] dtr;
        logic signed [31:0] dt, u, q, w0, hsf, hhf, qw0, innov, s, k0, k1, a, b;
        r.st = it.cmd ? hkf_pkg::ST_CORR : hkf_pkg::ST_PRED;
        if (!it.cmd) begin
            dtr = it.stamp - m_last;
            m_last = it.stamp;
            if (dtr < k_min) begin
                r.st = hkf_pkg::ST_SHORT;
            end else begin
                dt = dtr[31] ? hkf_pkg::SMAX : dtr;
                u = sat_sub(it.accel, $signed({1'b0, k_grav}));
                q = $signed({1'b0, k_acc});
                w0 = fx_mul(dt, dt) >>> 1;
                m_h = sat_add(sat_add(m_h, fx_mul(dt, m_v)), fx_mul(w0, u));
                m_v = sat_add(m_v, fx_mul(dt, u));
                hsf = sat_add(m_hs, fx_mul(dt, m_ss));
                hhf = sat_add(sat_add(m_hh, fx_mul(dt, m_hs)), fx_mul(dt, hsf));
                qw0 = fx_mul(w0, q);
                m_hh = sat_add(hhf, fx_mul(w0, qw0));
                m_hs = sat_add(hsf, fx_mul(dt, qw0));
                m_ss = sat_add(m_ss, fx_mul(fx_mul(dt, q), dt));
            end
        end else if (it.rv > it.rl) begin
            r.st = hkf_pkg::ST_RANGE;
        end else begin
            innov = sat_sub($signed({1'b0, it.rv}), m_h);
            s = sat_add(m_hh, $signed({1'b0, k_son}));
            k0 = fx_div(m_hh, s);
            k1 = fx_div(m_hs, s);
            m_h = sat_add(m_h, fx_mul(k0, innov));
            m_v = sat_add(m_v, fx_mul(k1, innov));
            a = m_hh;
            b = m_hs;
            m_hh = sat_sub(a, fx_mul(k0, a));
            m_hs = sat_sub(b, fx_mul(k0, b));
            m_ss = sat_sub(m_ss, fx_mul(k1, b));
        end
        r.h = m_h;
        r.v = m_v;
        r.hh = m_hh;
        r.hs = m_hs;
        r.ss = m_ss;
        return r;
    endfunction

    function automatic bit roll(input bit sender);
        int pct;
        pct = 0;
        if (mode == 3) pct = 22;
        else if (sender && mode == 1) pct = 72;
        else if (!sender && mode == 2) pct = 72;
        return $urandom_range(99) < pct;
    endfunction

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    int hold_cnt = 0;
    always @(posedge i_clk) begin
        t_est e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending.size() == 0) begin
                $error("result with none expected: height %h status %0d", o_height, o_status);
                fails++;
            end else begin
                e = pending.pop_front();
                if (o_height !== e.h) begin
                    $error("height exp %h got %h", e.h, o_height); fails++;
                end
                if (o_vertical_speed !== e.v) begin
                    $error("vertical_speed exp %h got %h", e.v, o_vertical_speed); fails++;
                end
                if (o_height_var !== e.hh) begin
                    $error("height_var exp %h got %h", e.hh, o_height_var); fails++;
                end
                if (o_cross_cov !== e.hs) begin
                    $error("cross_cov exp %h got %h", e.hs, o_cross_cov); fails++;
                end
                if (o_speed_var !== e.ss) begin
                    $error("speed_var exp %h got %h", e.ss, o_speed_var); fails++;
                end
                if (o_status !== e.st) begin
                    $error("status exp %0d got %0d", e.st, o_status); fails++;
                end
            end
        end
        if (hold_req && hold_cnt == 0) begin
            hold_cnt = HOLD_LEN;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_stall <= 1;
        end else begin
            i_stall <= roll(0);
        end
    end

    task automatic send(input t_item it, input logic known, input logic [1:0] kst);
        t_est e;
        if (roll(1)) begin
            i_valid <= 0;
            @(posedge i_clk);
            while (roll(1)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_cmd <= it.cmd;
        i_stamp <= it.stamp;
        i_accel_z <= it.accel;
        i_range_value <= it.rv;
        i_range_limit <= it.rl;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        e = filter_step(it);
        if (known) begin
            e.h = 0; e.v = 0; e.hh = COV0; e.hs = COV0; e.ss = COV0; e.st = kst;
        end
        pending.push_back(e);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            hkf_pkg::REG_ACCEL: k_acc = val[30:0];
            hkf_pkg::REG_SONAR: k_son = val[30:0];
            hkf_pkg::REG_GRAV:  k_grav = val[30:0];
            hkf_pkg::REG_MIN:   k_min = val;
            default: ;
        endcase
    endtask

    task automatic add_row(input logic cmd, input logic [31:0] stamp,
                           input logic [31:0] accel, input logic [30:0] rv,
                           input logic [30:0] rl, input logic known,
                           input logic [1:0] kst, input logic cfg_en,
                           input logic [2:0] idx, input logic [31:0] dat);
        t_row r;
        r.it.cmd = cmd;
        r.it.stamp = stamp;
        r.it.accel = accel;
        r.it.rv = rv;
        r.it.rl = rl;
        r.known = known;
        r.kst = kst;
        r.cfg_en = cfg_en;
        r.cfg_idx = idx;
        r.cfg_dat = dat;
        rows.push_back(r);
    endtask

    function automatic t_item random_item();
        t_item it;
        int r;
        it.cmd = $urandom_range(99) >= 55;
        it.stamp = $urandom;
        it.accel = $urandom;
        it.rv = 31'($urandom);
        it.rl = 31'($urandom);
        if (!it.cmd) begin
            r = $urandom_range(99);
            if (r < 80) it.stamp = m_last + $urandom_range(2000);
            else if (r < 90) it.stamp = m_last + $urandom_range(k_min > 400 ? 400 : k_min);
            if ($urandom_range(99) < 70)
                it.accel = $signed({1'b0, k_grav}) + $signed($urandom_range(524288)) - 262144;
        end else begin
            if ($urandom_range(99) < 70) it.rv = 31'($urandom_range(20 << 16));
            if ($urandom_range(99) < 85 && it.rl < it.rv) it.rl = it.rv;
        end
        return it;
    endfunction

    initial begin
        t_item it;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        add_row(0, 32'd10, 0, 0, 0, 1, hkf_pkg::ST_SHORT, 0, 0, 0);
        add_row(1, 0, 0, 31'h7FFFFFFF, 31'd0, 1, hkf_pkg::ST_RANGE, 0, 0, 0);
        add_row(0, 32'd76, 0, 31'h7FFFFFFF, 0, 0, 0, 0, 0, 0);
        add_row(0, 32'd731, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 32'd1386, 32'h80000000, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, 32'hFFFFFFFF, 0, 31'd0, 31'd0, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 31'd6553600, 31'h7FFFFFFF, 0, 0, 0, 0, 0);
        add_row(0, 32'hFFFFFFF0, 32'd642908, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 32'h00000010, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 32'h80000010, 32'd1000, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 31'd327680, 31'd655360, 0, 0, 1, hkf_pkg::REG_SONAR, 32'd0);
        add_row(1, 0, 0, 31'd100, 31'd655360, 0, 0, 0, 0, 0);
        add_row(0, 32'h80000400, 32'hFFF00000, 0, 0, 0, 0, 1, hkf_pkg::REG_SONAR,
                32'd13107);
        add_row(1, 0, 0, 31'd65536, 31'd65536, 0, 0, 0, 0, 0);

        foreach (rows[i]) begin
            if (rows[i].cfg_en) begin
                drain();
                write_reg(rows[i].cfg_idx, rows[i].cfg_dat);
            end
            send(rows[i].it, rows[i].known, rows[i].kst);
        end

        for (int p = 0; p < 7; p++) begin
            drain();
            mode = p % 4;
            if (p > 0) begin
                write_reg(hkf_pkg::REG_ACCEL, p == 1 ? 32'd0 : p == 2 ? 32'h7FFFFFFF
                                                           : $urandom_range(65536));
                write_reg(hkf_pkg::REG_SONAR, p == 1 ? 32'd0 : p == 2 ? 32'h7FFFFFFF
                                                           : $urandom_range(65536));
                write_reg(hkf_pkg::REG_GRAV, p == 1 ? 32'd0 : p == 2 ? 32'h7FFFFFFF
                                                          : $urandom_range(700000));
                write_reg(hkf_pkg::REG_MIN, p == 1 ? 32'd0 : p == 2 ? 32'hFFFFFFFF
                                                         : $urandom_range(400));
                write_reg(hkf_pkg::REG_START, p == 1 ? 32'h80000000 : $urandom);
            end
            for (int n = 0; n < 250; n++) begin
                if (p == 0 && n == 20) hold_req = 1;
                it = random_item();
                send(it, 0, 0);
            end
        end

        drain();
        if (fails == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
